### src/full_linear_convolution_fir_top_macros.svh
// Assertion macros for the convolution filter checker
`ifndef FULL_LINEAR_CONVOLUTION_FIR_TOP_MACROS_SVH
`define FULL_LINEAR_CONVOLUTION_FIR_TOP_MACROS_SVH

// check outside reset only
`define FLCF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// check at every edge, reset included
`define FLCF_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/flcf_pkg.sv
// Types, constants and register codes of the convolution filter
package flcf_pkg;

	localparam int SAMPLE_BITS  = 16;
	localparam int COEF_BITS    = 16;
	localparam int RESULT_BITS  = 34;
	localparam int NUM_COEFS    = 7;
	localparam int MAX_TAPS_DEF = 7;
	localparam int TAP_W        = 3;
	localparam int HALF_W       = 2;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;
	localparam int JOB_DEPTH    = 2;
	localparam int OUT_DEPTH    = 4;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [COEF_BITS-1:0]   coef_t;
	typedef logic signed [RESULT_BITS-1:0] acc_t;

	localparam coef_t COEF0_RESET = coef_t'(32767);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HALF_LENGTH = 3'd0,
		REG_COEF_0      = 3'd1,
		REG_COEF_1      = 3'd2,
		REG_COEF_2      = 3'd3,
		REG_COEF_3      = 3'd4,
		REG_COEF_4      = 3'd5,
		REG_COEF_5      = 3'd6,
		REG_COEF_6      = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		sample_t sample;
		logic    last_sample;
	} in_item_t;

	typedef struct packed {
		acc_t result;
		logic last_result;
	} out_item_t;

	typedef struct packed {
		logic [TAP_W-1:0] taps;
		logic             last;
	} job_ctl_t;

endpackage

### src/flcf_fifo.sv
// Small register queue with occupancy count
module flcf_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [WIDTH-1:0]           wr_data,
	input  logic                       rd_en,
	output logic [WIDTH-1:0]           rd_data,
	output logic                       full,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign rd_data = mem_q[rd_ptr_q];
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

### src/flcf_front.sv
// Front end: sample intake, delay line and job classification
module flcf_front import flcf_pkg::*; #(
	parameter int LANES = NUM_COEFS,
	parameter int WIN_W = LANES * SAMPLE_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  in_item_t          item,
	input  logic [HALF_W-1:0] half_length,
	input  logic              job_full,
	output logic              job_wr,
	output job_ctl_t          job_ctl,
	output logic [WIN_W-1:0]  job_win
);

	logic             accept;
	logic [TAP_W-1:0] taps_raw;
	sample_t          win [LANES];

	assign accept   = push && !job_full;
	assign job_wr   = accept;
	assign taps_raw = {half_length, 1'b1};

	always_comb begin
		job_ctl.last = item.last_sample;
		if (taps_raw > TAP_W'(LANES)) begin
			job_ctl.taps = TAP_W'(LANES);
		end else begin
			job_ctl.taps = taps_raw;
		end
	end

	assign win[0] = item.sample;

	if (LANES > 1) begin : g_delay
		sample_t dl_q [LANES-1];

		for (genvar j = 1; j < LANES; j++) begin : g_tap
			assign win[j] = dl_q[j-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				for (int i = 0; i < LANES - 1; i++) begin
					dl_q[i] <= '0;
				end
			end else if (accept) begin
				for (int i = 0; i < LANES - 1; i++) begin
					if (item.last_sample) begin
						dl_q[i] <= '0;
					end else begin
						dl_q[i] <= win[i];
					end
				end
			end
		end
	end

	always_comb begin
		for (int j = 0; j < LANES; j++) begin
			job_win[j*SAMPLE_BITS +: SAMPLE_BITS] = win[j];
		end
	end

endmodule

### src/flcf_back.sv
// Back end: output sequencing and multiply-accumulate pipeline
module flcf_back import flcf_pkg::*; #(
	parameter int LANES = NUM_COEFS,
	parameter int WIN_W = LANES * SAMPLE_BITS,
	parameter int ODEPTH = OUT_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        job_empty,
	input  job_ctl_t                    job_ctl,
	input  logic [WIN_W-1:0]            job_win,
	output logic                        job_pop,
	input  coef_t                       coef [NUM_COEFS],
	input  logic [$clog2(ODEPTH+1)-1:0] out_count,
	output logic                        out_wr,
	output out_item_t                   out_data
);

	localparam int CNT_W  = $clog2(ODEPTH + 1);
	localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
	localparam int PAIRS  = (LANES + 1) / 2;

	logic [TAP_W-1:0]        t_q;
	logic [TAP_W-1:0]        final_t;
	logic [CNT_W:0]          pending;
	logic                    issue;
	sample_t                 win [LANES];
	sample_t                 sel [LANES];
	logic signed [PROD_W-1:0] mul [LANES];

	acc_t prod_s1 [LANES];
	logic v_s1;
	logic flag_s1;
	acc_t psum_s2 [PAIRS];
	logic v_s2;
	logic flag_s2;

	always_comb begin
		for (int j = 0; j < LANES; j++) begin
			win[j] = job_win[j*SAMPLE_BITS +: SAMPLE_BITS];
		end
	end

	assign final_t = job_ctl.last ? job_ctl.taps - TAP_W'(1) : '0;
	assign pending = {1'b0, out_count} + (CNT_W+1)'(v_s1) + (CNT_W+1)'(v_s2);
	assign issue   = !job_empty && (pending < (CNT_W+1)'(ODEPTH));
	assign job_pop = issue && (t_q == final_t);

	// shift the window by the tail index
	always_comb begin
		for (int j = 0; j < LANES; j++) begin
			sel[j] = '0;
			for (int k = 0; k <= j; k++) begin
				if (t_q == TAP_W'(j - k)) begin
					sel[j] = win[k];
				end
			end
			mul[j] = PROD_W'(coef[j]) * PROD_W'(sel[j]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_q  <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (issue) begin
				if (job_pop) begin
					t_q <= '0;
				end else begin
					t_q <= t_q + TAP_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		flag_s1 <= job_ctl.last && (t_q == job_ctl.taps - TAP_W'(1));
		for (int j = 0; j < LANES; j++) begin
			if ((TAP_W'(j) >= t_q) && (TAP_W'(j) < job_ctl.taps)) begin
				prod_s1[j] <= RESULT_BITS'(mul[j]);
			end else begin
				prod_s1[j] <= '0;
			end
		end
		flag_s2 <= flag_s1;
		for (int i = 0; i < PAIRS; i++) begin
			if (2 * i + 1 < LANES) begin
				psum_s2[i] <= prod_s1[2*i] + prod_s1[2*i+1];
			end else begin
				psum_s2[i] <= prod_s1[2*i];
			end
		end
	end

	always_comb begin
		out_data.result = '0;
		for (int i = 0; i < PAIRS; i++) begin
			out_data.result = out_data.result + psum_s2[i];
		end
		out_data.last_result = flag_s2;
	end

	assign out_wr = v_s2;

endmodule

### src/full_linear_convolution_fir_top.sv
// Path: job queue, stage-1 products, stage-2 pair sums, then the result queue.
// Throughput: one result per cycle while a job waits and the result queue has room;
// one result per plain sample, one per tap per last sample; one shared MAC pipeline.
// Reset: asynchronous, active low; clears the delay line, both queues and the
// registers (half_length 0, coef_0 32767, other taps 0).
// Top level of the full linear convolution filter
module full_linear_convolution_fir_top import flcf_pkg::*; #(
	parameter int MAX_TAPS = MAX_TAPS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  in_item_t              item,
	input  logic                  pop,
	output logic                  empty,
	output out_item_t             result_item,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int LANES = (MAX_TAPS < NUM_COEFS) ? MAX_TAPS : NUM_COEFS;
	localparam int WIN_W = LANES * SAMPLE_BITS;
	localparam int JOB_W = WIN_W + $bits(job_ctl_t);
	localparam int OCNT_W = $clog2(OUT_DEPTH + 1);

	logic [HALF_W-1:0] half_length_q;
	coef_t             coef_q [NUM_COEFS];

	logic              job_wr;
	job_ctl_t          job_ctl_wr;
	logic [WIN_W-1:0]  job_win_wr;
	logic [JOB_W-1:0]  job_rd;
	logic              job_empty;
	logic              job_pop;
	job_ctl_t          job_ctl_rd;
	logic [WIN_W-1:0]  job_win_rd;

	logic              out_wr;
	out_item_t         out_data;
	logic [OCNT_W-1:0] out_count;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_length_q <= '0;
			coef_q[0]     <= COEF0_RESET;
			for (int i = 1; i < NUM_COEFS; i++) begin
				coef_q[i] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_HALF_LENGTH: half_length_q <= cfg_data[HALF_W-1:0];
				default:         coef_q[cfg_index - CFG_IDX_W'(1)] <= coef_t'(cfg_data);
			endcase
		end
	end

	flcf_front #(
		.LANES(LANES),
		.WIN_W(WIN_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.item       (item),
		.half_length(half_length_q),
		.job_full   (full),
		.job_wr     (job_wr),
		.job_ctl    (job_ctl_wr),
		.job_win    (job_win_wr)
	);

	flcf_fifo #(
		.WIDTH(JOB_W),
		.DEPTH(JOB_DEPTH)
	) u_job_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (job_wr),
		.wr_data({job_ctl_wr, job_win_wr}),
		.rd_en  (job_pop),
		.rd_data(job_rd),
		.full   (full),
		.empty  (job_empty),
		.count  ()
	);

	assign job_ctl_rd = job_ctl_t'(job_rd[JOB_W-1:WIN_W]);
	assign job_win_rd = job_rd[WIN_W-1:0];

	flcf_back #(
		.LANES (LANES),
		.WIN_W (WIN_W),
		.ODEPTH(OUT_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_empty(job_empty),
		.job_ctl  (job_ctl_rd),
		.job_win  (job_win_rd),
		.job_pop  (job_pop),
		.coef     (coef_q),
		.out_count(out_count),
		.out_wr   (out_wr),
		.out_data (out_data)
	);

	flcf_fifo #(
		.WIDTH($bits(out_item_t)),
		.DEPTH(OUT_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (out_wr),
		.wr_data(out_data),
		.rd_en  (pop),
		.rd_data(result_item),
		.full   (),
		.empty  (empty),
		.count  (out_count)
	);

endmodule

### src/flcf_checker.sv
// Port-level assertions for the convolution filter, bound to the top level
`include "full_linear_convolution_fir_top_macros.svh"

module flcf_checker import flcf_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      full,
	input logic      pop,
	input logic      empty,
	input out_item_t result_item
);

	`FLCF_ASSERT_ALWAYS(a_rst_empty, !arst_n |=> empty, "result queue not empty in reset")
	`FLCF_ASSERT_ALWAYS(a_rst_full, !arst_n |=> !full, "input side full in reset")
	`FLCF_ASSERT(a_hold, (!empty && !pop) |=> (!empty && $stable(result_item)), "result not held")

endmodule

bind full_linear_convolution_fir_top flcf_checker u_flcf_checker (.*);

### test/tb_top.sv
`timescale 1ns / 100ps
// Testbench of the full linear convolution filter: queue-fed driver, result monitor, predictor
module tb_top;
	import flcf_pkg::*;

	localparam int TAPS_MAX      = MAX_TAPS_DEF;
	localparam int IDLE_PCT      = 23;
	localparam int SETTLE_CYCLES = 12;
	localparam int MAX_REPORTS   = 10;
	localparam int PHASE_ITEMS   = 14;

	localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam coef_t   COEF_MAX   = {1'b0, {(COEF_BITS-1){1'b1}}};
	localparam coef_t   COEF_MIN   = {1'b1, {(COEF_BITS-1){1'b0}}};

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  push      = 1'b0;
	logic                  full;
	in_item_t              item      = '0;
	logic                  pop       = 1'b0;
	logic                  empty;
	out_item_t             result_item;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	logic [HALF_W-1:0] half_len = '0;
	coef_t             tap_coef [NUM_COEFS];
	coef_t             staged_coef [NUM_COEFS];
	sample_t           delay_hist [TAPS_MAX-1];
	in_item_t          sample_queue [$];
	out_item_t         expected_out [$];
	bit                calm   = 1'b0;
	int                errors = 0;

	full_linear_convolution_fir_top i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.item        (item),
		.pop         (pop),
		.empty       (empty),
		.result_item (result_item),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic predict_convolution(input in_item_t it);
		sample_t   win [TAPS_MAX];
		int        taps;
		longint    acc;
		out_item_t o;
		taps = 2 * half_len + 1;
		if (taps > TAPS_MAX)
			taps = TAPS_MAX;
		win[0] = it.sample;
		for (int j = 1; j < TAPS_MAX; j++)
			win[j] = delay_hist[j-1];
		acc = 0;
		for (int j = 0; j < taps; j++)
			acc += longint'(tap_coef[j]) * longint'(win[j]);
		o.result      = acc[RESULT_BITS-1:0];
		o.last_result = it.last_sample && taps == 1;
		expected_out.push_back(o);
		if (it.last_sample) begin
			for (int t = 1; t < taps; t++) begin
				acc = 0;
				for (int j = t; j < taps; j++)
					acc += longint'(tap_coef[j]) * longint'(win[j-t]);
				o.result      = acc[RESULT_BITS-1:0];
				o.last_result = (t == taps - 1);
				expected_out.push_back(o);
			end
			for (int j = 0; j < TAPS_MAX - 1; j++)
				delay_hist[j] = '0;
		end else begin
			for (int j = 0; j < TAPS_MAX - 1; j++)
				delay_hist[j] = win[j];
		end
	endtask

	task automatic check_result(input out_item_t got);
		out_item_t want;
		if (expected_out.size() == 0) begin
			errors = errors + 1;
			if (errors <= MAX_REPORTS)
				$display("unexpected result %0d last %0b",
					$signed(got.result), got.last_result);
		end else begin
			want = expected_out.pop_front();
			if (got.result !== want.result || got.last_result !== want.last_result) begin
				errors = errors + 1;
				if (errors <= MAX_REPORTS)
					$display("mismatch: expected %0d last %0b, got %0d last %0b",
						$signed(want.result), want.last_result,
						$signed(got.result), got.last_result);
			end
		end
	endtask

	// sample transfer side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else if (!push || !full) begin
			if (push)
				predict_convolution(item);
			if (sample_queue.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
				item <= sample_queue.pop_front();
				push <= 1'b1;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// result transfer side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty)
				check_result(result_item);
			pop <= calm || $urandom_range(99) >= IDLE_PCT;
		end
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_HALF_LENGTH)
			half_len = data[HALF_W-1:0];
		else
			tap_coef[int'(idx) - int'(REG_COEF_0)] = coef_t'(data);
	endtask

	task automatic program_filter(input logic [CFG_DATA_W-1:0] hword);
		write_reg(REG_HALF_LENGTH, hword);
		for (int i = 0; i < NUM_COEFS; i++)
			write_reg(cfg_reg_t'(int'(REG_COEF_0) + i), staged_coef[i]);
	endtask

	task automatic wait_idle();
		while (sample_queue.size() != 0 || push || expected_out.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic sample_t rand_sample();
		case ($urandom_range(9))
			0: rand_sample = SAMPLE_MAX;
			1: rand_sample = SAMPLE_MIN;
			default: rand_sample = sample_t'($urandom);
		endcase
	endfunction

	function automatic coef_t rand_coef();
		case ($urandom_range(7))
			0: rand_coef = COEF_MAX;
			1: rand_coef = COEF_MIN;
			2: rand_coef = '0;
			default: rand_coef = coef_t'($urandom);
		endcase
	endfunction

	function automatic void add_sample(input sample_t s, input logic last);
		in_item_t it;
		it.sample      = s;
		it.last_sample = last;
		sample_queue.push_back(it);
	endfunction

	function automatic void add_signal(input int len, input bit finish);
		for (int i = 0; i < len; i++)
			add_sample(rand_sample(), finish && i == len - 1);
	endfunction

	function automatic void fill_coefs(input coef_t c);
		for (int i = 0; i < NUM_COEFS; i++)
			staged_coef[i] = c;
	endfunction

	function automatic void random_coefs();
		for (int i = 0; i < NUM_COEFS; i++)
			staged_coef[i] = rand_coef();
	endfunction

	initial begin
		logic [CFG_DATA_W-1:0] hword;
		int                    n;
		int                    len;
		for (int i = 0; i < NUM_COEFS; i++)
			tap_coef[i] = '0;
		tap_coef[0] = COEF0_RESET;
		for (int j = 0; j < TAPS_MAX - 1; j++)
			delay_hist[j] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// single tap after reset, each sample gives one output
		add_sample(SAMPLE_MAX, 1'b0);
		add_sample(SAMPLE_MIN, 1'b0);
		add_sample(sample_t'(1), 1'b1);
		wait_idle();

		// longest filter at the largest sum of products
		fill_coefs(COEF_MIN);
		program_filter(3);
		repeat (7) add_sample(SAMPLE_MIN, 1'b0);
		add_sample(SAMPLE_MIN, 1'b1);
		wait_idle();

		// large negative sums, signal left open
		fill_coefs(COEF_MAX);
		program_filter(3);
		repeat (3) add_sample(SAMPLE_MIN, 1'b0);
		wait_idle();

		// shorten the filter mid-signal, then a one-sample signal
		random_coefs();
		program_filter(1);
		add_sample(SAMPLE_MAX, 1'b0);
		add_sample(rand_sample(), 1'b0);
		add_sample(SAMPLE_MIN, 1'b1);
		add_sample(SAMPLE_MAX, 1'b1);
		wait_idle();

		random_coefs();
		program_filter(2);
		add_sample(SAMPLE_MAX, 1'b0);
		add_sample(sample_t'(-1), 1'b0);
		add_sample(sample_t'(0), 1'b0);
		add_sample(SAMPLE_MIN, 1'b1);
		wait_idle();

		for (int ph = 0; ph < 6; ph++) begin
			calm = (ph == 2);
			hword = CFG_DATA_W'($urandom);
			if (ph == 0)
				hword[HALF_W-1:0] = '0;
			random_coefs();
			program_filter(hword);
			n = 0;
			while (n < PHASE_ITEMS) begin
				len = ($urandom_range(3) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
				add_signal(len, n + len < PHASE_ITEMS || $urandom_range(3) != 0);
				n += len;
			end
			wait_idle();
		end

		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#400000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

### sim.f
+incdir+src
src/flcf_pkg.sv
src/flcf_fifo.sv
src/flcf_front.sv
src/flcf_back.sv
src/full_linear_convolution_fir_top.sv
src/flcf_checker.sv
test/tb_top.sv
